// ===== sv/svo_pkg.sv =====
// ----------------------------------------------------------------------------
// svo_pkg
// shared types, constants and codes for the sparse voxel octree insert block
// ----------------------------------------------------------------------------
package svo_pkg;

    localparam int MAX_DEPTH    = 16;
    localparam int POOL_ENTRIES = 65536;
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int FREE_W       = IDX_W + 1;
    localparam int COORD_W      = 16;
    localparam int MID_W        = COORD_W + 2;
    localparam int DEPTH_W      = 5;
    localparam int GROUP_SIZE   = 8;
    localparam int ROOT_INDEX   = 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [DEPTH_W-1:0]   RST_TREE_DEPTH = DEPTH_W'(16);
    localparam logic [COORD_W-1:0]   RST_CENTER     = COORD_W'(32768);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_DEPTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COORD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_LOCK  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LOCKED    = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LEVEL,
        S_LEAF_RD,
        S_LEAF_WR,
        S_DONE
    } t_state;

    typedef logic signed [MID_W-1:0] t_mid;

    typedef struct packed {
        logic             solid;
        logic [7:0]       flags;
        logic [IDX_W-1:0] child;
    } t_node;

    // outcome of one descent level
    typedef struct packed {
        t_node              wr_node;
        logic [IDX_W-1:0]   next_node;
        logic               alloc;
        logic               exhausted;
        t_mid               mx;
        t_mid               my;
        t_mid               mz;
        logic [COORD_W-1:0] half;
    } t_step;

endpackage

// ===== sv/svo_node_mem.sv =====
// ----------------------------------------------------------------------------
// svo_node_mem
// node store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module svo_node_mem
    import svo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_node            i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_node            o_rdata
);

    t_node r_mem [POOL_ENTRIES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/svo_level.sv =====
// ----------------------------------------------------------------------------
// svo_level
// one descent level: octant select, midpoint update and child allocation
// ----------------------------------------------------------------------------
module svo_level
    import svo_pkg::*;
(
    input  t_node              i_node,
    input  logic [COORD_W-1:0] i_cx,
    input  logic [COORD_W-1:0] i_cy,
    input  logic [COORD_W-1:0] i_cz,
    input  t_mid               i_mx,
    input  t_mid               i_my,
    input  t_mid               i_mz,
    input  logic [COORD_W-1:0] i_half,
    input  logic [FREE_W-1:0]  i_next_free,
    output t_step              o_step
);

    logic [COORD_W-1:0] half;
    t_mid               half_s;
    logic               bx;
    logic               by;
    logic               bz;
    logic [2:0]         oct;
    logic               need_alloc;
    logic               exhausted;
    logic [IDX_W-1:0]   child;

    always_comb begin
        half   = i_half >> 1;
        half_s = t_mid'({2'b00, half});
        // coordinates are non-negative, so a negative midpoint is always below
        bx  = t_mid'({2'b00, i_cx}) >= i_mx;
        by  = t_mid'({2'b00, i_cy}) >= i_my;
        bz  = t_mid'({2'b00, i_cz}) >= i_mz;
        oct = {bz, by, bx};

        need_alloc = (i_node.child == '0);
        exhausted  = need_alloc &&
                     (({1'b0, i_next_free} + (FREE_W+1)'(GROUP_SIZE)) >
                      (FREE_W+1)'(POOL_ENTRIES));
        child      = need_alloc ? i_next_free[IDX_W-1:0] : i_node.child;

        o_step.wr_node.solid = 1'b1;
        if (exhausted) begin
            o_step.wr_node.flags = i_node.flags;
            o_step.wr_node.child = i_node.child;
        end else begin
            o_step.wr_node.flags = i_node.flags | (8'd1 << oct);
            o_step.wr_node.child = child;
        end
        o_step.next_node = child + IDX_W'(oct);
        o_step.alloc     = need_alloc && !exhausted;
        o_step.exhausted = exhausted;
        o_step.mx        = bx ? i_mx + half_s : i_mx - half_s;
        o_step.my        = by ? i_my + half_s : i_my - half_s;
        o_step.mz        = bz ? i_mz + half_s : i_mz - half_s;
        o_step.half      = half;
    end

endmodule

// ===== sv/sparse_voxel_octree_insert.sv =====
// ----------------------------------------------------------------------------
// sparse_voxel_octree_insert
// inserts one voxel per transaction into a sparse voxel octree node store
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one voxel coordinate; the
// output channel (o_out_valid / i_out_ready) returns one result per insert:
// status, leaf store index and the number of child groups newly taken.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data, index
// 0 tree depth, 1 centre coordinate, 2 stream lock; the user must write it only
// while the block is idle, and the block itself does not enforce this. After
// reset the node store is swept to zero, one entry a cycle, over all 65536
// entries; o_in_ready stays low until the sweep is done. Each level is a read
// then a modify-write of the node store over its single read and single write
// port, then the leaf entry is read and marked solid unless the pool ran out;
// a locked insert goes straight to its result. One insert is worked on at a
// time: a new coordinate is taken only after the previous result is placed
// in the output register. The result sits in an output register,
// so the next coordinate can be accepted while it waits; if the receiver
// still stalls when the next result is ready, the walk holds until the
// output register is free.
// ----------------------------------------------------------------------------
module sparse_voxel_octree_insert
    import svo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_W-1:0]    i_coord_x,
    input  logic [COORD_W-1:0]    i_coord_y,
    input  logic [COORD_W-1:0]    i_coord_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [IDX_W-1:0]      o_leaf_index,
    output logic [DEPTH_W-1:0]    o_groups_allocated
);

    t_state              r_state;
    t_state              n_state;
    logic [IDX_W-1:0]    r_clr;
    logic [DEPTH_W-1:0]  r_tree_depth;
    logic [COORD_W-1:0]  r_center;
    logic                r_lock;
    logic [FREE_W-1:0]   r_next_free;
    logic [DEPTH_W-1:0]  r_depth;
    logic [DEPTH_W-1:0]  r_lvl;
    logic [IDX_W-1:0]    r_node;
    t_mid                r_mx;
    t_mid                r_my;
    t_mid                r_mz;
    logic [COORD_W-1:0]  r_half;
    logic [DEPTH_W-1:0]  r_groups;
    t_status             r_status;
    logic [COORD_W-1:0]  r_cx;
    logic [COORD_W-1:0]  r_cy;
    logic [COORD_W-1:0]  r_cz;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [IDX_W-1:0]    r_out_leaf;
    logic [DEPTH_W-1:0]  r_out_groups;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_node               mem_wdata;
    logic                mem_re;
    t_node               mem_rdata;
    t_step               step;
    logic [DEPTH_W-1:0]  sat_depth;
    logic                in_take;
    logic                out_free;

    svo_node_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_node),
        .o_rdata (mem_rdata)
    );

    svo_level u_level (
        .i_node      (mem_rdata),
        .i_cx        (r_cx),
        .i_cy        (r_cy),
        .i_cz        (r_cz),
        .i_mx        (r_mx),
        .i_my        (r_my),
        .i_mz        (r_mz),
        .i_half      (r_half),
        .i_next_free (r_next_free),
        .o_step      (step)
    );

    assign sat_depth = (r_tree_depth > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                            : r_tree_depth;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_take    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth <= RST_TREE_DEPTH;
            r_center     <= RST_CENTER;
            r_lock       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TREE_DEPTH:   r_tree_depth <= i_cfg_data[DEPTH_W-1:0];
                CFG_CENTER_COORD: r_center     <= i_cfg_data[COORD_W-1:0];
                CFG_STREAM_LOCK:  r_lock       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = step.wr_node;
        mem_re    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_take) begin
                    if (r_lock) begin
                        n_state = S_DONE;
                    end else if (sat_depth == '0) begin
                        n_state = S_LEAF_RD;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                mem_we = 1'b1;
                if (step.exhausted) begin
                    n_state = S_DONE;
                end else if (r_lvl + DEPTH_W'(1) == r_depth) begin
                    n_state = S_LEAF_RD;
                end else begin
                    n_state = S_READ;
                end
            end
            S_LEAF_RD: begin
                mem_re  = 1'b1;
                n_state = S_LEAF_WR;
            end
            S_LEAF_WR: begin
                mem_we          = 1'b1;
                mem_wdata       = mem_rdata;
                mem_wdata.solid = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // walk control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_next_free <= FREE_W'(GROUP_SIZE);
            r_groups    <= '0;
            r_lvl       <= '0;
            r_status    <= ST_OK;
        end else begin
            case (r_state)
                S_CLEAR: r_clr <= r_clr + IDX_W'(1);
                S_IDLE: begin
                    if (in_take) begin
                        r_groups <= '0;
                        r_lvl    <= '0;
                        r_status <= r_lock ? ST_LOCKED : ST_OK;
                    end
                end
                S_LEVEL: begin
                    if (step.exhausted) begin
                        r_status <= ST_EXHAUSTED;
                    end else begin
                        r_lvl <= r_lvl + DEPTH_W'(1);
                        if (step.alloc) begin
                            r_next_free <= r_next_free + FREE_W'(GROUP_SIZE);
                            r_groups    <= r_groups + DEPTH_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_cx    <= i_coord_x;
                    r_cy    <= i_coord_y;
                    r_cz    <= i_coord_z;
                    r_depth <= sat_depth;
                    r_node  <= IDX_W'(ROOT_INDEX);
                    r_mx    <= t_mid'({2'b00, r_center});
                    r_my    <= t_mid'({2'b00, r_center});
                    r_mz    <= t_mid'({2'b00, r_center});
                    r_half  <= (sat_depth == '0) ? '0
                                                 : COORD_W'(1) << (sat_depth - DEPTH_W'(1));
                end
            end
            S_LEVEL: begin
                r_node <= step.next_node;
                r_mx   <= step.mx;
                r_my   <= step.my;
                r_mz   <= step.mz;
                r_half <= step.half;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_leaf   <= (r_status == ST_OK) ? r_node : '0;
            r_out_groups <= r_groups;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_leaf_index       = r_out_leaf;
    assign o_groups_allocated = r_out_groups;

`ifndef SYNTH
    a_free_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_free[2:0] == 3'd0) && (r_next_free <= FREE_W'(POOL_ENTRIES)))
        else $error("free pointer off group boundary or beyond pool");

    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEVEL) |-> (r_lvl < r_depth))
        else $error("descent past configured depth");

    a_no_write_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != S_CLEAR) |-> (mem_waddr != '0))
        else $error("node write to unused entry zero");

    a_leaf_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_leaf_index == '0))
        else $error("leaf index returned on failed insert");

    a_groups_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_groups <= r_depth || r_status == ST_LOCKED))
        else $error("more groups taken than levels walked");
`endif

endmodule
